// ===== sv/cubic_bezier_axis_eval_macros.svh =====
// Assertion macros used by the checker file of the Bezier axis evaluator.
`ifndef CUBIC_BEZIER_AXIS_EVAL_MACROS_SVH
`define CUBIC_BEZIER_AXIS_EVAL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define CBZ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define CBZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cbz_pkg.sv =====
// Types and constants shared by the Bezier axis evaluator modules.
`default_nettype none

package cbz_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TW     = 13;
  localparam int unsigned FracW  = 12;
  localparam int unsigned ProdW  = CoordW + TW + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [TW-1:0]     tpar_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  // Half an LSB of the Q.12 result, added before the arithmetic shift.
  localparam prod_t RoundHalf = prod_t'(1) <<< (FracW - 1);

  // One beat in flight. The accumulator is folded with add0 at each Horner
  // step, after which the pending addends move down by one place.
  typedef struct packed {
    logic   vld;
    tpar_t  t;
    coord_t acc;
    coord_t add0;
    coord_t add1;
    coord_t add2;
  } beat_t;

endpackage

`default_nettype wire

// ===== sv/cbz_coef.sv =====
// Input stage: forms the four polynomial coefficients from the control points.
`default_nettype none

module cbz_coef (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  wire                   vld_in,
  input  wire  cbz_pkg::coord_t p0,
  input  wire  cbz_pkg::coord_t p1,
  input  wire  cbz_pkg::coord_t p2,
  input  wire  cbz_pkg::coord_t p3,
  input  wire  cbz_pkg::tpar_t  t,
  output cbz_pkg::beat_t        beat_out
);

  cbz_pkg::coord_t p0x3, p1x3, p2x3;
  cbz_pkg::beat_t  beat_r, beat_nxt;

  // All coefficient arithmetic wraps at the coordinate width.
  assign p0x3 = (p0 <<< 1) + p0;
  assign p1x3 = (p1 <<< 1) + p1;
  assign p2x3 = (p2 <<< 1) + p2;

  always_comb begin
    beat_nxt      = beat_r;
    beat_nxt.vld  = vld_in;
    beat_nxt.t    = t;
    beat_nxt.acc  = p1x3 - p0 - p2x3 + p3;
    beat_nxt.add0 = p0x3 - (p1x3 <<< 1) + p2x3;
    beat_nxt.add1 = p1x3 - p0x3;
    beat_nxt.add2 = p0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else if (en) begin
      beat_r.vld <= beat_nxt.vld;
    end
    if (en) begin
      beat_r.t    <= beat_nxt.t;
      beat_r.acc  <= beat_nxt.acc;
      beat_r.add0 <= beat_nxt.add0;
      beat_r.add1 <= beat_nxt.add1;
      beat_r.add2 <= beat_nxt.add2;
    end
  end

  assign beat_out = beat_r;

endmodule

`default_nettype wire

// ===== sv/cbz_step.sv =====
// One Horner step over two stages: multiply by t, then round, shift and add.
`default_nettype none

module cbz_step (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             en,
  input  wire cbz_pkg::beat_t beat_in,
  output cbz_pkg::beat_t  beat_out
);

  cbz_pkg::prod_t prod_r, prod_nxt, rnd;
  cbz_pkg::beat_t mid_r;
  cbz_pkg::beat_t out_r, out_nxt;

  // Signed accumulator times unsigned t; t gets a zero sign bit.
  assign prod_nxt = cbz_pkg::prod_t'(beat_in.acc) *
                    cbz_pkg::prod_t'($signed({1'b0, beat_in.t}));

  assign rnd = prod_r + cbz_pkg::RoundHalf;

  always_comb begin
    out_nxt      = mid_r;
    out_nxt.acc  = rnd[cbz_pkg::FracW +: cbz_pkg::CoordW] + mid_r.add0;
    out_nxt.add0 = mid_r.add1;
    out_nxt.add1 = mid_r.add2;
    out_nxt.add2 = mid_r.add2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.vld <= 1'b0;
      out_r.vld <= 1'b0;
    end else if (en) begin
      mid_r.vld <= beat_in.vld;
      out_r.vld <= out_nxt.vld;
    end
    if (en) begin
      prod_r     <= prod_nxt;
      mid_r.t    <= beat_in.t;
      mid_r.acc  <= beat_in.acc;
      mid_r.add0 <= beat_in.add0;
      mid_r.add1 <= beat_in.add1;
      mid_r.add2 <= beat_in.add2;
      out_r.t    <= out_nxt.t;
      out_r.acc  <= out_nxt.acc;
      out_r.add0 <= out_nxt.add0;
      out_r.add1 <= out_nxt.add1;
      out_r.add2 <= out_nxt.add2;
    end
  end

  assign beat_out = out_r;

endmodule

`default_nettype wire

// ===== sv/cubic_bezier_axis_eval.sv =====
// Top level of the cubic Bezier single-axis evaluator pipeline.
// Usage: each input beat carries the four control-point coordinates p0..p3
// (signed Q20.12) and the parameter t (unsigned, 4096 = 1.0). The block
// returns one beat with coord, the curve coordinate at t, in signed Q20.12.
// A 3D point is three beats, one per axis, in any order the user chooses.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. From input acceptance to out_valid a beat passes one coefficient
// stage, then three Horner steps of two stages each (multiplier, then round
// and add). Throughput is one beat per cycle unless out_stall holds a beat.
// The whole pipeline advances together; when the output register holds a
// beat that the receiver stalls, every stage freezes and in_stall is raised
// in the same cycle, so nothing is dropped or repeated. Empty stages do not
// collapse while frozen.
// Synchronous reset clears all valid bits; data registers are not reset.
`default_nettype none

module cubic_bezier_axis_eval (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  cbz_pkg::coord_t in_p0,
  input  wire  cbz_pkg::coord_t in_p1,
  input  wire  cbz_pkg::coord_t in_p2,
  input  wire  cbz_pkg::coord_t in_p3,
  input  wire  cbz_pkg::tpar_t  in_t,
  output logic                  out_valid,
  input  wire                   out_stall,
  output cbz_pkg::coord_t       out_coord
);

  localparam int unsigned NSteps = 3;

  logic           adv;
  cbz_pkg::beat_t beats [NSteps+1];

  assign adv      = !(beats[NSteps].vld && out_stall);
  assign in_stall = !adv;

  cbz_coef u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .vld_in   (in_valid),
    .p0       (in_p0),
    .p1       (in_p1),
    .p2       (in_p2),
    .p3       (in_p3),
    .t        (in_t),
    .beat_out (beats[0])
  );

  for (genvar i = 0; i < NSteps; i++) begin : g_step
    cbz_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .beat_in  (beats[i]),
      .beat_out (beats[i+1])
    );
  end

  assign out_valid = beats[NSteps].vld;
  assign out_coord = beats[NSteps].acc;

endmodule

`default_nettype wire

// ===== sv/cbz_checker.sv =====
// Port-level assertions for the Bezier axis evaluator, bound to the top level.
`default_nettype none
`include "cubic_bezier_axis_eval_macros.svh"

module cbz_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_stall,
  input wire  cbz_pkg::coord_t in_p0,
  input wire  cbz_pkg::coord_t in_p3,
  input wire  cbz_pkg::tpar_t  in_t,
  input wire                   out_valid,
  input wire                   out_stall,
  input wire  cbz_pkg::coord_t out_coord
);

  localparam cbz_pkg::tpar_t TZero = '0;
  localparam cbz_pkg::tpar_t TOne  = cbz_pkg::tpar_t'(1) << cbz_pkg::FracW;

  `CBZ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_coord), "stalled output beat changed")
  `CBZ_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a stalled output beat")
  `CBZ_ASSERT_NEXT(a_t_zero, in_valid && !in_stall && in_t == TZero ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall, out_valid && out_coord == ($past(in_p0, 7)), "t of zero did not give p0 after seven cycles")
  `CBZ_ASSERT_NEXT(a_t_one, in_valid && !in_stall && in_t == TOne ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall, out_valid && out_coord == ($past(in_p3, 7)), "t of one did not give p3 after seven cycles")

endmodule

bind cubic_bezier_axis_eval cbz_checker u_cbz_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_p0     (in_p0),
  .in_p3     (in_p3),
  .in_t      (in_t),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_coord (out_coord)
);

`default_nettype wire
